// ===== hw/rtl/lobs_pkg.sv =====
// Shared types and constants for the Luenberger observer block.
package lobs_pkg;
   localparam int SIG_W   = 24;
   localparam int COEF_W  = 18;
   localparam int ADDR_W  = 6;
   localparam int DEPTH   = 64;
   localparam int PROD_W  = SIG_W + COEF_W;
   localparam int ACC_W   = PROD_W + 8;

   typedef enum logic [1:0] {
      REQ_STEP = 2'd0,
      REQ_COEF = 2'd1,
      REQ_EST  = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [ADDR_W-1:0]        index;
      logic signed [SIG_W-1:0]  value;
      logic signed [SIG_W-1:0]  meas_0;
      logic signed [SIG_W-1:0]  meas_1;
      logic signed [SIG_W-1:0]  ctl_0;
      logic signed [SIG_W-1:0]  ctl_1;
   } req_beat_type;

   typedef struct packed {
      logic                     was_step;
      logic signed [SIG_W-1:0]  est_out_0;
      logic signed [SIG_W-1:0]  est_out_1;
      logic                     sat_flag;
   } rsp_beat_type;

   // MAC control from sequencer
   typedef struct packed {
      logic clear;   // start a new dot product with this term
      logic en;      // accumulate this term
   } mac_ctl_type;

   // round Q.26 to Q.12 half up, then saturate
   function automatic logic [SIG_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      logic [SIG_W:0] res;
      r = (acc + ACC_W'(8192)) >>> 14;
      if (r > ACC_W'(8388607))
         res = {1'b1, 24'sh7FFFFF};
      else if (r < -ACC_W'(8388608))
         res = {1'b1, 24'sh800000};
      else
         res = {1'b0, r[SIG_W-1:0]};
      return res;
   endfunction
endpackage

// ===== hw/rtl/lobs_if.sv =====
// Valid/ready channel interfaces for request and response beats.
interface lobs_req_if;
   logic                 valid;
   logic                 ready;
   lobs_pkg::req_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lobs_rsp_if;
   logic                 valid;
   logic                 ready;
   lobs_pkg::rsp_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/luenberger_observer_step_top.sv =====
// Top level of the fixed-point Luenberger observer.
// Request channel (req_*): one beat per item. A step beat carries measurements
// and controls; a coefficient beat writes one word of the 64-entry table
// (A, B, C, D, L row-major); an estimate beat writes one estimate element.
// Response channel (rsp_*): exactly one beat per request beat, in order.
// A step returns the predicted output y = C*x + D*u from the old estimate and
// the saturation flag; load and unused beats return all-zero fields.
// A step runs on one shared multiply-accumulate unit fed from the coefficient
// memory: each row's terms are issued in turn, then drained through the read,
// product and accumulate stages before the next row (default sizes: 2 rows
// of 6 terms, 4 rows of 8 terms); a done state closes the step. A load beat's
// response is registered and valid in the cycle after the beat is taken.
// The block handles one item at a time; req_ready is low while a step runs
// or a response beat waits, so a new load waits for the previous response.
// Reset clears the estimate and control state at once; the coefficient table
// is cleared by a sweep over all 64 entries after reset, with req_ready low.
// A stalled receiver holds the response beat; nothing is lost.
module luenberger_observer_step_top #(
   parameter int N_STATES = 4,
   parameter int N_MEAS   = 2,
   parameter int N_CTRL   = 2
) (
   input  logic       clock,
   input  logic       reset,
   lobs_req_if.sink   req,
   lobs_rsp_if.source rsp
);
   logic [lobs_pkg::ADDR_W:0] clr_ff;
   logic clearing;
   logic busy_ff;
   logic rsp_valid_ff;
   lobs_pkg::rsp_beat_type rsp_ff;
   logic accept, start_step;
   logic done;
   lobs_pkg::rsp_beat_type step_rsp;
   logic [lobs_pkg::ADDR_W-1:0] raddr;
   logic signed [lobs_pkg::COEF_W-1:0] coef;
   logic we;
   logic [lobs_pkg::ADDR_W-1:0] waddr;
   logic [lobs_pkg::COEF_W-1:0] wdata;

   assign clearing = !clr_ff[lobs_pkg::ADDR_W];
   assign req.ready = !clearing && !busy_ff && !rsp_valid_ff;
   assign accept = req.valid && req.ready;
   assign start_step = accept && req.data.req_type == lobs_pkg::REQ_STEP;

   assign we    = clearing || (accept && req.data.req_type == lobs_pkg::REQ_COEF);
   assign waddr = clearing ? clr_ff[lobs_pkg::ADDR_W-1:0] : req.data.index;
   assign wdata = clearing ? '0 : req.data.value[lobs_pkg::COEF_W-1:0];

   lobs_coef_mem u_mem (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (coef)
   );

   lobs_seq #(
      .N_STATES (N_STATES),
      .N_MEAS   (N_MEAS),
      .N_CTRL   (N_CTRL)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .req   (req.data),
      .coef  (coef),
      .raddr (raddr),
      .done  (done),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing)
            clr_ff <= clr_ff + 1'b1;
         if (start_step)
            busy_ff <= 1'b1;
         if (done) begin
            busy_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (accept && !start_step)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
      end
      if (done)
         rsp_ff <= step_rsp;
      else if (accept && !start_step)
         rsp_ff <= '0;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.ready) else $error("request taken during step");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("step done while idle");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !accept) else $error("request taken while clearing");
endmodule

// ===== hw/rtl/lobs_mac.sv =====
// Shared multiply-accumulate unit with one registered product stage.
module lobs_mac (
   input  logic                                  clock,
   input  lobs_pkg::mac_ctl_type                 ctl,
   input  logic signed [lobs_pkg::COEF_W-1:0]    coef,
   input  logic signed [lobs_pkg::SIG_W-1:0]     sig,
   output logic signed [lobs_pkg::ACC_W-1:0]     acc
);
   logic signed [lobs_pkg::PROD_W-1:0] prod_ff, prod_in;
   lobs_pkg::mac_ctl_type              ctl_ff;
   logic signed [lobs_pkg::ACC_W-1:0]  acc_ff, acc_in;

   assign prod_in = lobs_pkg::PROD_W'(coef) * lobs_pkg::PROD_W'(sig);

   always_comb begin
      acc_in = acc_ff;
      if (ctl_ff.en) begin
         if (ctl_ff.clear)
            acc_in = lobs_pkg::ACC_W'(prod_ff);
         else
            acc_in = acc_ff + lobs_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ctl_ff  <= ctl;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// ===== hw/rtl/lobs_coef_mem.sv =====
// Coefficient memory with registered read; the top level clears it after reset through the write port.
module lobs_coef_mem (
   input  logic                                clock,
   input  logic                                we,
   input  logic [lobs_pkg::ADDR_W-1:0]         waddr,
   input  logic [lobs_pkg::COEF_W-1:0]         wdata,
   input  logic [lobs_pkg::ADDR_W-1:0]         raddr,
   output logic signed [lobs_pkg::COEF_W-1:0]  rdata
);
   logic [lobs_pkg::COEF_W-1:0] mem [lobs_pkg::DEPTH];
   logic [lobs_pkg::COEF_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/lobs_seq.sv =====
// Step sequencer: walks the dot products, drives the MAC and updates the estimate.
module lobs_seq #(
   parameter int N_STATES = 4,
   parameter int N_MEAS   = 2,
   parameter int N_CTRL   = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  lobs_pkg::req_beat_type               req,
   input  logic signed [lobs_pkg::COEF_W-1:0]   coef,
   output logic [lobs_pkg::ADDR_W-1:0]          raddr,
   output logic                                 done,
   output lobs_pkg::rsp_beat_type               rsp
);
   localparam int NT   = N_STATES + N_CTRL + N_MEAS;   // terms per row, max
   localparam int TW   = $clog2(NT + 1);
   localparam int NR   = N_MEAS + N_STATES;
   localparam int RW   = $clog2(NR + 1);
   localparam int XW   = (N_STATES > 1) ? $clog2(N_STATES) : 1;
   localparam int OFS_A = 0;
   localparam int OFS_B = OFS_A + N_STATES * N_STATES;
   localparam int OFS_C = OFS_B + N_STATES * N_CTRL;
   localparam int OFS_D = OFS_C + N_MEAS * N_STATES;
   localparam int OFS_L = OFS_D + N_MEAS * N_CTRL;
   localparam int AW   = 8;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_WAIT = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [TW-1:0] term_ff, term_in;
   logic [1:0]    drain_ff, drain_in;

   // estimate memory: old values read, new values written to the other bank
   logic signed [lobs_pkg::SIG_W-1:0] est_mem [2][N_STATES];
   logic bank_ff;
   logic signed [lobs_pkg::SIG_W-1:0] est_rd_ff;
   logic signed [lobs_pkg::SIG_W-1:0] y_ff [2];
   logic signed [lobs_pkg::SIG_W-1:0] e_ff [2];
   logic sat_ff;
   logic signed [lobs_pkg::SIG_W-1:0] meas_ff [2];
   logic signed [lobs_pkg::SIG_W-1:0] ctl_ff [2];

   logic [AW-1:0] addr_full;
   logic [TW-1:0] nterm;
   logic term_valid;
   logic is_x, is_u;
   logic [XW-1:0] xidx;
   logic [0:0] jidx;
   logic row_is_y;
   logic [RW-1:0] srow;

   // operand source pipeline aligned with memory read latency
   logic [1:0] src_ff;        // 0 x, 1 u, 2 e
   logic [0:0] j_ff;
   lobs_pkg::mac_ctl_type ctl_p, mctl_ff;
   logic signed [lobs_pkg::SIG_W-1:0] sig;
   logic signed [lobs_pkg::COEF_W-1:0] cval;
   logic signed [lobs_pkg::ACC_W-1:0] acc;
   logic [lobs_pkg::SIG_W:0] rs;
   logic signed [lobs_pkg::SIG_W+1:0] diff;
   logic row_done_p, row_done_m, row_done_q, row_done_r;
   logic [RW-1:0] rrow_p, rrow_q, rrow_r;
   logic addr_ok_ff;

   assign row_is_y = (row_ff < RW'(N_MEAS));
   assign srow = row_ff - RW'(N_MEAS);
   assign nterm = row_is_y ? TW'(N_STATES + N_CTRL) : TW'(NT);
   assign term_valid = (state_ff == S_RUN);
   assign is_x = (term_ff < TW'(N_STATES));
   assign is_u = !is_x && (term_ff < TW'(N_STATES + N_CTRL));
   assign xidx = XW'(term_ff);

   always_comb begin
      jidx = '0;
      addr_full = '0;
      if (is_x) begin
         addr_full = row_is_y ? AW'(OFS_C + N_STATES * row_ff + term_ff)
                              : AW'(OFS_A + N_STATES * srow + term_ff);
      end else if (is_u) begin
         jidx = 1'(term_ff - TW'(N_STATES));
         addr_full = row_is_y ? AW'(OFS_D + N_CTRL * row_ff + jidx)
                              : AW'(OFS_B + N_CTRL * srow + jidx);
      end else begin
         jidx = 1'(term_ff - TW'(N_STATES + N_CTRL));
         addr_full = AW'(OFS_L + N_MEAS * srow + jidx);
      end
   end

   assign raddr = addr_full[lobs_pkg::ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      term_in = term_ff;
      drain_in = drain_ff;
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && req.req_type == lobs_pkg::REQ_STEP) begin
               state_in = S_RUN;
               row_in = '0;
               term_in = '0;
            end
         end
         S_RUN: begin
            if (term_ff == nterm - TW'(1)) begin
               term_in = '0;
               state_in = S_WAIT;
               drain_in = '0;
            end else begin
               term_in = term_ff + TW'(1);
            end
         end
         S_WAIT: begin
            // let the row drain through read, product and accumulate stages
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd3) begin
               if (row_ff == RW'(NR - 1))
                  state_in = S_DONE;
               else begin
                  row_in = row_ff + RW'(1);
                  state_in = S_RUN;
               end
            end
         end
         S_DONE: begin
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign ctl_p.en = term_valid;
   assign ctl_p.clear = (term_ff == '0);
   assign row_done_p = term_valid && (term_ff == nterm - TW'(1));

   always_comb begin
      unique case (src_ff)
         2'd0: sig = est_rd_ff;
         2'd1: sig = ctl_ff[j_ff];
         default: sig = e_ff[j_ff];
      endcase
      cval = addr_ok_ff ? coef : '0;
   end

   lobs_mac u_mac (
      .clock (clock),
      .ctl   (mctl_ff),
      .coef  (cval),
      .sig   (sig),
      .acc   (acc)
   );

   assign rs = lobs_pkg::round_sat(acc);
   assign diff = (lobs_pkg::SIG_W+2)'(meas_ff[rrow_r[0]])
               - (lobs_pkg::SIG_W+2)'($signed(rs[lobs_pkg::SIG_W-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bank_ff  <= 1'b0;
         mctl_ff  <= '0;
         row_done_m <= 1'b0;
         row_done_q <= 1'b0;
         row_done_r <= 1'b0;
         for (int b = 0; b < 2; b++)
            for (int k = 0; k < N_STATES; k++)
               est_mem[b][k] <= '0;
      end else begin
         state_ff <= state_in;
         mctl_ff  <= ctl_p;
         // the row-done flag of the last term follows it through the m, q and r registers to the accumulator
         row_done_m <= row_done_p;
         row_done_q <= row_done_m;
         row_done_r <= row_done_q;
         if (start && req.req_type == lobs_pkg::REQ_EST
             && 32'(req.index) < N_STATES)
            est_mem[bank_ff][XW'(req.index)] <= req.value;
         if (row_done_r && rrow_r >= RW'(N_MEAS))
            est_mem[~bank_ff][XW'(rrow_r - RW'(N_MEAS))] <= $signed(rs[lobs_pkg::SIG_W-1:0]);
         if (done)
            bank_ff <= ~bank_ff;
      end
      row_ff <= row_in;
      term_ff <= term_in;
      drain_ff <= drain_in;
      est_rd_ff <= est_mem[bank_ff][xidx];
      src_ff <= is_x ? 2'd0 : (is_u ? 2'd1 : 2'd2);
      j_ff <= jidx;
      addr_ok_ff <= (addr_full < AW'(lobs_pkg::DEPTH));
      rrow_p <= row_ff;
      rrow_q <= rrow_p;
      rrow_r <= rrow_q;
      if (state_ff == S_IDLE && start) begin
         sat_ff <= 1'b0;
         meas_ff[0] <= req.meas_0;
         meas_ff[1] <= (N_MEAS > 1) ? req.meas_1 : '0;
         ctl_ff[0] <= req.ctl_0;
         ctl_ff[1] <= (N_CTRL > 1) ? req.ctl_1 : '0;
         y_ff[0] <= '0;
         y_ff[1] <= '0;
      end else if (row_done_r) begin
         if (rs[lobs_pkg::SIG_W])
            sat_ff <= 1'b1;
         if (rrow_r < RW'(N_MEAS)) begin
            y_ff[rrow_r[0]] <= $signed(rs[lobs_pkg::SIG_W-1:0]);
            if (diff > (lobs_pkg::SIG_W+2)'(8388607)) begin
               e_ff[rrow_r[0]] <= 24'sh7FFFFF;
               sat_ff <= 1'b1;
            end else if (diff < -(lobs_pkg::SIG_W+2)'(8388608)) begin
               e_ff[rrow_r[0]] <= 24'sh800000;
               sat_ff <= 1'b1;
            end else
               e_ff[rrow_r[0]] <= diff[lobs_pkg::SIG_W-1:0];
         end
      end
   end

   assign rsp.was_step  = 1'b1;
   assign rsp.est_out_0 = y_ff[0];
   assign rsp.est_out_1 = y_ff[1];
   assign rsp.sat_flag  = sat_ff;
endmodule

// ===== bench/tb_luenberger_observer_step_top.sv =====
// Testbench for the fixed-point Luenberger observer: directed loads and steps, then random.
module tb_luenberger_observer_step_top;
   localparam int NS = 4, NM = 2, NC = 2;
   localparam int OFS_B = NS*NS, OFS_C = OFS_B + NS*NC, OFS_D = OFS_C + NM*NS;
   localparam int OFS_L = OFS_D + NM*NC;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lobs_req_if req_if ();
   lobs_rsp_if rsp_if ();

   luenberger_observer_step_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always #10 clock = ~clock;

   // observer shadow state
   logic signed [lobs_pkg::COEF_W-1:0] coef_mem [lobs_pkg::DEPTH];
   logic signed [lobs_pkg::SIG_W-1:0]  x_est [NS];
   lobs_pkg::rsp_beat_type             rsp_expected [$];

   int  mismatches = 0;
   int  n_steps = 0, n_sat = 0, n_loads = 0;
   int  idle_cycles = 0;
   bit  timed_out = 1'b0;
   bit  hold_off = 1'b0;

   function automatic logic signed [lobs_pkg::SIG_W-1:0] to_sig(input longint acc,
                                                               inout bit sat);
      longint r;
      r = (acc + 8192) >>> 14;
      if (r > 8388607) begin
         sat = 1'b1;
         return 24'sh7FFFFF;
      end
      if (r < -8388608) begin
         sat = 1'b1;
         return 24'sh800000;
      end
      return r[lobs_pkg::SIG_W-1:0];
   endfunction

   function automatic longint cw(input int a);
      return longint'(coef_mem[a]);
   endfunction

   function automatic lobs_pkg::rsp_beat_type observer_predict(input lobs_pkg::req_beat_type b);
      lobs_pkg::rsp_beat_type o;
      longint meas [2], u [2], e [2], acc, d;
      logic signed [lobs_pkg::SIG_W-1:0] y [2];
      logic signed [lobs_pkg::SIG_W-1:0] xn [NS];
      bit sat;
      o = '0;
      sat = 1'b0;
      case (b.req_type)
         lobs_pkg::REQ_COEF: coef_mem[b.index] = b.value[lobs_pkg::COEF_W-1:0];
         lobs_pkg::REQ_EST: if (b.index < NS) x_est[b.index] = b.value;
         lobs_pkg::REQ_STEP: begin
            meas[0] = b.meas_0; meas[1] = b.meas_1;
            u[0] = b.ctl_0;     u[1] = b.ctl_1;
            y[1] = '0;
            for (int i = 0; i < NM; i++) begin
               acc = 0;
               for (int j = 0; j < NS; j++) acc += cw(OFS_C + i*NS + j) * longint'(x_est[j]);
               for (int j = 0; j < NC; j++) acc += cw(OFS_D + i*NC + j) * u[j];
               y[i] = to_sig(acc, sat);
               d = meas[i] - longint'(y[i]);
               if (d > 8388607) begin
                  sat = 1'b1;
                  d = 8388607;
               end else if (d < -8388608) begin
                  sat = 1'b1;
                  d = -8388608;
               end
               e[i] = d;
            end
            for (int i = 0; i < NS; i++) begin
               acc = 0;
               for (int j = 0; j < NS; j++) acc += cw(i*NS + j) * longint'(x_est[j]);
               for (int j = 0; j < NC; j++) acc += cw(OFS_B + i*NC + j) * u[j];
               for (int j = 0; j < NM; j++) acc += cw(OFS_L + i*NM + j) * e[j];
               xn[i] = to_sig(acc, sat);
            end
            for (int i = 0; i < NS; i++) x_est[i] = xn[i];
            o.was_step = 1'b1;
            o.est_out_0 = y[0];
            o.est_out_1 = y[1];
            o.sat_flag = sat;
         end
         default: ;
      endcase
      return o;
   endfunction

   // sender
   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
   end

   // called at a falling edge; returns at a falling edge with valid low
   task automatic send_beat(input lobs_pkg::req_beat_type b);
      req_if.data = b;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      rsp_expected.push_back(observer_predict(b));
      if (b.req_type == lobs_pkg::REQ_STEP) n_steps++; else n_loads++;
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // bursty sender gaps
   int burst_left = 0;
   task automatic send_paced(input lobs_pkg::req_beat_type b);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      send_beat(b);
   endtask

   function automatic logic signed [lobs_pkg::SIG_W-1:0] rand_sig();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return lobs_pkg::SIG_W'($urandom_range(0, 8192)) - 24'sd4096;
         default: return lobs_pkg::SIG_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [lobs_pkg::SIG_W-1:0] rand_coef();
      case ($urandom_range(0, 4))
         0: return 24'sh01FFFF;
         1: return 24'sh020000;
         2: return lobs_pkg::SIG_W'($urandom_range(0, 8192)) - 24'sd4096;
         default: return lobs_pkg::SIG_W'($urandom);
      endcase
   endfunction

   function automatic lobs_pkg::req_beat_type make_beat(input lobs_pkg::req_code_type t,
                                                        input int idx,
                                                        input logic signed [23:0] v);
      lobs_pkg::req_beat_type b;
      b = '0;
      b.req_type = t;
      b.index = idx[lobs_pkg::ADDR_W-1:0];
      b.value = v;
      return b;
   endfunction

   function automatic lobs_pkg::req_beat_type make_step();
      lobs_pkg::req_beat_type b;
      b = make_beat(lobs_pkg::REQ_STEP, $urandom_range(0, 63), lobs_pkg::SIG_W'($urandom));
      b.meas_0 = rand_sig(); b.meas_1 = rand_sig();
      b.ctl_0 = rand_sig();  b.ctl_1 = rand_sig();
      return b;
   endfunction

   task automatic wait_drained();
      while (rsp_expected.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      lobs_pkg::req_beat_type b;
      send_beat(make_step());                  // all-zero table
      for (int a = 0; a < OFS_L + NS*NM; a++)
         send_beat(make_beat(lobs_pkg::REQ_COEF, a,
                             (a % 5 == 0) ? 24'sh01FFFF : 24'sh020000));
      send_beat(make_beat(lobs_pkg::REQ_COEF, 63, 24'shFFFFFF));
      send_beat(make_beat(lobs_pkg::REQ_EST, 0, 24'sh7FFFFF));
      send_beat(make_beat(lobs_pkg::REQ_EST, 3, 24'sh800000));
      send_beat(make_beat(lobs_pkg::REQ_EST, 63, 24'sh123456)); // out of range, no write
      send_beat(make_beat(lobs_pkg::REQ_NONE, 5, 24'sh7FFFFF));
      b = make_step();
      b.meas_0 = 24'sh7FFFFF; b.meas_1 = 24'sh800000;
      b.ctl_0 = 24'sh800000;  b.ctl_1 = 24'sh7FFFFF;
      send_beat(b);
      send_beat(make_step());
   endtask

   task automatic load_table_random();
      for (int a = 0; a < lobs_pkg::DEPTH; a++)
         send_paced(make_beat(lobs_pkg::REQ_COEF, a, rand_coef()));
      for (int i = 0; i < NS; i++) send_paced(make_beat(lobs_pkg::REQ_EST, i, rand_sig()));
   endtask

   task automatic test_random();
      int r;
      for (int n = 0; n < 800; n++) begin
         r = $urandom_range(0, 99);
         if (r < 75) send_paced(make_step());
         else if (r < 88)
            send_paced(make_beat(lobs_pkg::REQ_COEF, $urandom_range(0, 63), rand_coef()));
         else if (r < 97)
            send_paced(make_beat(lobs_pkg::REQ_EST, $urandom_range(0, 63), rand_sig()));
         else
            send_paced(make_beat(lobs_pkg::REQ_NONE, $urandom_range(0, 63),
                                 lobs_pkg::SIG_W'($urandom)));
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int n = 0; n < 6; n++) send_beat(make_step());
      wait_drained();
      // sender pause: nothing outstanding, then restart
      repeat (3) send_beat(make_step());
   endtask

   // receiver stall pattern, plus a long hold-off on request
   initial begin
      int hold;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
            hold = 0;
            while (hold < 400) begin
               @(negedge clock);
               hold++;
            end
            hold_off = 1'b0;
         end else if (($urandom_range(0, 255) & 8'h70) == 8'h70) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      lobs_pkg::rsp_beat_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (rsp_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", got);
         end else begin
            want = rsp_expected.pop_front();
            if (got.sat_flag && got.was_step) n_sat++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected step=%0d y0=%0d y1=%0d sat=%0d,",
                            " got step=%0d y0=%0d y1=%0d sat=%0d"},
                     want.was_step, want.est_out_0, want.est_out_1, want.sat_flag,
                     got.was_step, got.est_out_0, got.est_out_1, got.sat_flag);
            end
         end
      end
   end

   // watchdog: counts cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb_luenberger_observer_step_top: done, errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < lobs_pkg::DEPTH; i++) coef_mem[i] = '0;
      for (int i = 0; i < NS; i++) x_est[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      load_table_random();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (100) @(negedge clock);
      $display("covered %0d steps (%0d saturating) and %0d load/unused beats",
               n_steps, n_sat, n_loads);
      if (mismatches == 0 && rsp_expected.size() == 0)
         $display("tb_luenberger_observer_step_top: done, clean");
      else
         $display("tb_luenberger_observer_step_top: done, errors");
      $finish;
   end
endmodule
